// File: sv/tet_scaled_jacobian_quality_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled Jacobian quality block
// ----------------------------------------------------------------------------
`ifndef TET_SCALED_JACOBIAN_QUALITY_ASSERT_SVH
`define TET_SCALED_JACOBIAN_QUALITY_ASSERT_SVH

// condition holds at every edge out of reset
`define TSJ_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define TSJ_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TSJ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tsj_pkg.sv
// ----------------------------------------------------------------------------
// tsj_pkg
// Widths, request/response types and flags for the scaled Jacobian block.
// ----------------------------------------------------------------------------
package tsj_pkg;

    localparam int COORD_BITS     = 16;
    localparam int FRAC_BITS      = 16;
    localparam int QUAL_BITS      = FRAC_BITS + 2;
    localparam int MUL_STAGES_DEF = 4;

    localparam int EDGE_W = COORD_BITS + 1;
    localparam int LEN_W  = 2 * COORD_BITS + 2;
    localparam int XP_W   = 2 * COORD_BITS + 1;
    localparam int CRS_W  = 2 * COORD_BITS + 2;
    localparam int JT_W   = EDGE_W + CRS_W;
    localparam int JAC_W  = JT_W + 2;
    localparam int PROD_W = 3 * LEN_W;
    localparam int JSQ_W  = 2 * JAC_W;
    localparam int DEN_W  = (PROD_W > JSQ_W) ? PROD_W : JSQ_W;
    localparam int QUO_W  = 2 * FRAC_BITS + 2;
    localparam int ROOT_W = FRAC_BITS + 1;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] az;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] bz;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic signed [COORD_BITS-1:0] dx;
        logic signed [COORD_BITS-1:0] dy;
        logic signed [COORD_BITS-1:0] dz;
    } t_req;

    typedef struct packed {
        logic signed [QUAL_BITS-1:0] quality;
        logic                        degenerate;
    } t_rsp;

    typedef struct packed {
        logic neg;
        logic degen;
    } t_flags;

endpackage

// File: sv/tsj_mul.sv
// ----------------------------------------------------------------------------
// tsj_mul
// Pipelined unsigned multiplier: B is cut into NSTG chunks, one partial
// product accumulated per stage. A side word travels along with the data.
// ----------------------------------------------------------------------------
module tsj_mul #(
    parameter int AW   = 34,
    parameter int BW   = 34,
    parameter int NSTG = 4,
    parameter int SW   = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [SW-1:0]    i_side,
    output logic             o_valid,
    output logic [AW+BW-1:0] o_p,
    output logic [SW-1:0]    o_side
);
    localparam int CW  = (BW + NSTG - 1) / NSTG;
    localparam int BPW = CW * NSTG;
    localparam int PW  = AW + BW;

    logic [PW-1:0]  r_acc  [NSTG];
    logic [AW-1:0]  r_a    [NSTG];
    logic [BPW-1:0] r_b    [NSTG];
    logic [SW-1:0]  r_side [NSTG];
    logic           r_vld  [NSTG];

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        localparam int SH = k * CW;
        logic [PW-1:0]      acc_in;
        logic [AW-1:0]      a_in;
        logic [BPW-1:0]     b_in;
        logic [SW-1:0]      side_in;
        logic               vld_in;
        logic [AW+CW-1:0]   pp;
        logic [PW-1:0]      n_acc;

        if (k == 0) begin : g_first
            assign acc_in  = '0;
            assign a_in    = i_a;
            assign b_in    = BPW'(i_b);
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign acc_in  = r_acc[k-1];
            assign a_in    = r_a[k-1];
            assign b_in    = r_b[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        assign pp    = (AW+CW)'(a_in) * (AW+CW)'(b_in[SH +: CW]);
        assign n_acc = acc_in + (PW'(pp) << SH);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k]  <= n_acc;
                r_a[k]    <= a_in;
                r_b[k]    <= b_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_p     = r_acc[NSTG-1];
    assign o_side  = r_side[NSTG-1];

endmodule

// File: sv/tsj_div.sv
// ----------------------------------------------------------------------------
// tsj_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor((t << (QW-1)) / den), given t <= den and den > 0.
// ----------------------------------------------------------------------------
module tsj_div #(
    parameter int DW = 106,
    parameter int QW = 34,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_t,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_q,
    output logic [SW-1:0] o_side
);
    logic [DW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stg
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] q_in;
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic          bit_in;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_q;

        if (i == 0) begin : g_first
            // top part of the shifted numerator is t >> 1, then t[0], then zeros
            assign rem_in  = i_t >> 1;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
            assign bit_in  = i_t[0];
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign den_in  = r_den[i-1];
            assign q_in    = r_q[i-1];
            assign side_in = r_side[i-1];
            assign vld_in  = r_vld[i-1];
            assign bit_in  = 1'b0;
        end

        assign sh    = {rem_in, bit_in};
        assign diff  = sh - {1'b0, den_in};
        assign ge    = sh >= {1'b0, den_in};
        assign n_rem = ge ? diff[DW-1:0] : sh[DW-1:0];
        assign n_q   = {q_in[QW-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_den[i]  <= den_in;
                r_q[i]    <= n_q;
                r_side[i] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: sv/tsj_sqrt.sv
// ----------------------------------------------------------------------------
// tsj_sqrt
// Pipelined integer square root, one root bit (two radicand bits) per stage.
// ----------------------------------------------------------------------------
module tsj_sqrt #(
    parameter int XW = 34,
    parameter int SW = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [XW-1:0]   i_x,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [XW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);
    localparam int RB    = XW / 2;
    localparam int REM_W = RB + 2;

    logic [XW-1:0]    r_x    [RB];
    logic [REM_W-1:0] r_rem  [RB];
    logic [RB-1:0]    r_root [RB];
    logic [SW-1:0]    r_side [RB];
    logic             r_vld  [RB];

    for (genvar i = 0; i < RB; i++) begin : g_stg
        logic [XW-1:0]    x_in;
        logic [REM_W-1:0] rem_in;
        logic [RB-1:0]    root_in;
        logic [SW-1:0]    side_in;
        logic             vld_in;
        logic [REM_W+1:0] sh;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] res;
        logic             ge;
        logic [REM_W-1:0] n_rem;
        logic [RB-1:0]    n_root;

        if (i == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign x_in    = r_x[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign side_in = r_side[i-1];
            assign vld_in  = r_vld[i-1];
        end

        assign sh     = {rem_in, x_in[XW-1-2*i -: 2]};
        assign trial  = (REM_W+2)'({root_in, 2'b01});
        assign ge     = sh >= trial;
        assign res    = ge ? (sh - trial) : sh;
        assign n_rem  = res[REM_W-1:0];
        assign n_root = {root_in[RB-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i]    <= x_in;
                r_rem[i]  <= n_rem;
                r_root[i] <= n_root;
                r_side[i] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[RB-1];
    assign o_root  = r_root[RB-1];
    assign o_side  = r_side[RB-1];

endmodule

// File: sv/tet_scaled_jacobian_quality.sv
// ----------------------------------------------------------------------------
// tet_scaled_jacobian_quality
// Scaled Jacobian quality of one tetrahedron per request, Q.FRAC_BITS.
// Input channel: i_valid/o_stall with i_req (four corners). Output channel:
// o_valid/i_stall with o_rsp (quality, degenerate). A request is taken at an
// edge with valid high and stall low; each request gives one response.
// The path from acceptance to o_valid runs through the corner-product
// multiplier chain, the one-bit-per-stage divider and the one-bit-per-stage
// square root. Throughput: one request per cycle while o_stall is low;
// every stage advances together.
// When the receiver stalls, o_rsp holds; one more finished response parks in
// a skid register, and then o_stall rises until the output drains.
// Reset clears all valid bits, including the output and skid valid flags; the
// block takes requests in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "tet_scaled_jacobian_quality_assert.svh"

module tet_scaled_jacobian_quality #(
    parameter int MUL_STAGES = tsj_pkg::MUL_STAGES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tsj_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output tsj_pkg::t_rsp o_rsp
);
    import tsj_pkg::*;

    // edges meeting at each corner: a, b, c, d
    localparam int CA [4] = '{0, 0, 1, 3};
    localparam int CB [4] = '{2, 1, 2, 4};
    localparam int CC [4] = '{3, 4, 5, 5};

    logic adv;

    // ---------------- stage 1: edges
    logic signed [EDGE_W-1:0] pt   [4][3];
    logic signed [EDGE_W-1:0] n_e  [6][3];
    logic signed [EDGE_W-1:0] r1_e [6][3];
    logic                     r1_vld;

    assign pt[0][0] = EDGE_W'(i_req.ax);
    assign pt[0][1] = EDGE_W'(i_req.ay);
    assign pt[0][2] = EDGE_W'(i_req.az);
    assign pt[1][0] = EDGE_W'(i_req.bx);
    assign pt[1][1] = EDGE_W'(i_req.by);
    assign pt[1][2] = EDGE_W'(i_req.bz);
    assign pt[2][0] = EDGE_W'(i_req.cx);
    assign pt[2][1] = EDGE_W'(i_req.cy);
    assign pt[2][2] = EDGE_W'(i_req.cz);
    assign pt[3][0] = EDGE_W'(i_req.dx);
    assign pt[3][1] = EDGE_W'(i_req.dy);
    assign pt[3][2] = EDGE_W'(i_req.dz);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_e[0][k] = pt[1][k] - pt[0][k];
            n_e[1][k] = pt[2][k] - pt[1][k];
            n_e[2][k] = pt[0][k] - pt[2][k];
            n_e[3][k] = pt[3][k] - pt[0][k];
            n_e[4][k] = pt[3][k] - pt[1][k];
            n_e[5][k] = pt[3][k] - pt[2][k];
        end
    end

    // ---------------- stage 2: squared lengths, cross partial products
    logic signed [LEN_W-1:0]  sq     [6][3];
    logic [LEN_W-1:0]         n_len  [6];
    logic signed [XP_W-1:0]   n_xp   [6];
    logic [LEN_W-1:0]         r2_len [6];
    logic signed [XP_W-1:0]   r2_xp  [6];
    logic signed [EDGE_W-1:0] r2_e3  [3];
    logic                     r2_vld;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) begin
                sq[i][k] = LEN_W'(r1_e[i][k]) * LEN_W'(r1_e[i][k]);
            end
            n_len[i] = $unsigned(sq[i][0]) + $unsigned(sq[i][1]) + $unsigned(sq[i][2]);
        end
        n_xp[0] = XP_W'(r1_e[2][1]) * XP_W'(r1_e[0][2]);
        n_xp[1] = XP_W'(r1_e[2][2]) * XP_W'(r1_e[0][1]);
        n_xp[2] = XP_W'(r1_e[2][2]) * XP_W'(r1_e[0][0]);
        n_xp[3] = XP_W'(r1_e[2][0]) * XP_W'(r1_e[0][2]);
        n_xp[4] = XP_W'(r1_e[2][0]) * XP_W'(r1_e[0][1]);
        n_xp[5] = XP_W'(r1_e[2][1]) * XP_W'(r1_e[0][0]);
    end

    // ---------------- stage 3: cross product
    logic signed [CRS_W-1:0]  n_crs  [3];
    logic [LEN_W-1:0]         r3_len [6];
    logic signed [CRS_W-1:0]  r3_crs [3];
    logic signed [EDGE_W-1:0] r3_e3  [3];
    logic                     r3_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_crs[k] = CRS_W'(r2_xp[2*k]) - CRS_W'(r2_xp[2*k+1]);
        end
    end

    // ---------------- Jacobian path: terms, sum, magnitude
    logic signed [JT_W-1:0]  n_jt  [3];
    logic signed [JT_W-1:0]  r4_jt [3];
    logic                    r4_vld;
    logic signed [JAC_W-1:0] n_jac;
    logic signed [JAC_W-1:0] r5_jac;
    logic                    r5_vld;
    logic [JAC_W-1:0]        r6_jmag;
    logic                    r6_neg;
    logic                    r6_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_jt[k] = JT_W'(r3_e3[k]) * JT_W'(r3_crs[k]);
        end
        n_jac = JAC_W'(r4_jt[0]) + JAC_W'(r4_jt[1]) + JAC_W'(r4_jt[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
        end else if (adv) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_e   <= n_e;
            r2_len <= n_len;
            r2_xp  <= n_xp;
            for (int k = 0; k < 3; k++) begin
                r2_e3[k] <= r1_e[3][k];
            end
            r3_len <= r2_len;
            r3_crs <= n_crs;
            r3_e3  <= r2_e3;
            r4_jt  <= n_jt;
            r5_jac <= n_jac;
            r6_neg <= r5_jac[JAC_W-1];
            r6_jmag <= r5_jac[JAC_W-1] ? $unsigned(-r5_jac) : $unsigned(r5_jac);
        end
    end

    // ---------------- corner length products
    logic [2*LEN_W-1:0] w_p2   [4];
    logic [LEN_W-1:0]   w_lc   [4];
    logic [PROD_W-1:0]  w_prod [4];
    logic [3:0]         w_m1_vld;
    logic [3:0]         w_m2_vld;

    for (genvar g = 0; g < 4; g++) begin : g_corner
        tsj_mul #(
            .AW   (LEN_W),
            .BW   (LEN_W),
            .NSTG (MUL_STAGES),
            .SW   (LEN_W)
        ) u_mul_ab (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (r3_vld),
            .i_a     (r3_len[CA[g]]),
            .i_b     (r3_len[CB[g]]),
            .i_side  (r3_len[CC[g]]),
            .o_valid (w_m1_vld[g]),
            .o_p     (w_p2[g]),
            .o_side  (w_lc[g])
        );

        tsj_mul #(
            .AW   (2*LEN_W),
            .BW   (LEN_W),
            .NSTG (MUL_STAGES),
            .SW   (1)
        ) u_mul_c (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_m1_vld[g]),
            .i_a     (w_p2[g]),
            .i_b     (w_lc[g]),
            .i_side  (1'b0),
            .o_valid (w_m2_vld[g]),
            .o_p     (w_prod[g]),
            .o_side  ()
        );
    end

    // largest corner product, two compare levels
    logic [PROD_W-1:0] r_ma_max [2];
    logic              r_ma_vld;
    logic [PROD_W-1:0] r_mb_pm;
    logic              r_mb_vld;

    // ---------------- J squared, timed to land with the corner maximum
    logic [JSQ_W-1:0] w_jsq;
    logic             w_j_neg;
    logic             w_j_vld;

    tsj_mul #(
        .AW   (JAC_W),
        .BW   (JAC_W),
        .NSTG (2*MUL_STAGES-1),
        .SW   (1)
    ) u_mul_jsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r6_vld),
        .i_a     (r6_jmag),
        .i_b     (r6_jmag),
        .i_side  (r6_neg),
        .o_valid (w_j_vld),
        .o_p     (w_jsq),
        .o_side  (w_j_neg)
    );

    // ---------------- denominator select
    logic [DEN_W-1:0] jsq_x;
    logic [DEN_W-1:0] pm_x;
    logic [DEN_W-1:0] den;
    t_flags           n_d_flags;
    logic [DEN_W-1:0] r_d_t;
    logic [DEN_W-1:0] r_d_den;
    t_flags           r_d_flags;
    logic             r_d_vld;

    assign jsq_x           = DEN_W'(w_jsq);
    assign pm_x            = DEN_W'(r_mb_pm);
    assign den             = (jsq_x > pm_x) ? jsq_x : pm_x;
    assign n_d_flags.neg   = w_j_neg;
    assign n_d_flags.degen = (den == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ma_vld <= 1'b0;
            r_mb_vld <= 1'b0;
            r_d_vld  <= 1'b0;
        end else if (adv) begin
            r_ma_vld <= w_m2_vld[0];
            r_mb_vld <= r_ma_vld;
            r_d_vld  <= w_j_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ma_max[0] <= (w_prod[1] > w_prod[0]) ? w_prod[1] : w_prod[0];
            r_ma_max[1] <= (w_prod[3] > w_prod[2]) ? w_prod[3] : w_prod[2];
            r_mb_pm     <= (r_ma_max[1] > r_ma_max[0]) ? r_ma_max[1] : r_ma_max[0];
            r_d_t       <= jsq_x;
            r_d_den     <= den;
            r_d_flags   <= n_d_flags;
        end
    end

    // ---------------- quotient 2*J^2*2^(2F)/den, then its root
    logic [QUO_W-1:0]           w_quo;
    logic [$bits(t_flags)-1:0]  w_dv_side;
    logic                       w_dv_vld;
    logic [ROOT_W-1:0]          w_root;
    logic [$bits(t_flags)-1:0]  w_sq_side;
    logic                       w_fin_vld;

    tsj_div #(
        .DW (DEN_W),
        .QW (QUO_W),
        .SW ($bits(t_flags))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_d_vld),
        .i_t     (r_d_t),
        .i_den   (r_d_den),
        .i_side  (r_d_flags),
        .o_valid (w_dv_vld),
        .o_q     (w_quo),
        .o_side  (w_dv_side)
    );

    tsj_sqrt #(
        .XW (QUO_W),
        .SW ($bits(t_flags))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (w_dv_vld),
        .i_x     (w_quo),
        .i_side  (w_dv_side),
        .o_valid (w_fin_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // ---------------- sign, output register and skid
    t_flags                  fin_flags;
    logic signed [QUAL_BITS-1:0] mag;
    t_rsp                    fin;
    logic                    r_ov;
    t_rsp                    r_od;
    logic                    r_sv;
    t_rsp                    r_sd;

    assign fin_flags      = t_flags'(w_sq_side);
    assign mag            = QUAL_BITS'(w_root);
    assign fin.quality    = fin_flags.degen ? '0 : (fin_flags.neg ? -mag : mag);
    assign fin.degenerate = fin_flags.degen;

    assign adv = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (!i_stall) begin
                r_sv <= 1'b0;
            end
        end else if (w_fin_vld) begin
            if (r_ov && i_stall) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (!i_stall) begin
                r_od <= r_sd;
            end
        end else if (w_fin_vld) begin
            if (r_ov && i_stall) begin
                r_sd <= fin;
            end else begin
                r_od <= fin;
            end
        end
    end

    assign o_stall = r_sv;
    assign o_valid = r_ov;
    assign o_rsp   = r_od;

    `TSJ_ASSERT_HOLDS(a_path_align, i_clk, i_rst_n, r_mb_vld == w_j_vld,
        "corner product and J squared paths out of step")
    `TSJ_ASSERT_HOLDS(a_corner_lockstep, i_clk, i_rst_n, w_m2_vld == {4{w_m2_vld[0]}},
        "corner multiplier chains out of step")
    `TSJ_ASSERT_IMPLIES(a_skid_behind_out, i_clk, i_rst_n, r_sv, r_ov,
        "skid register loaded while output register empty")
    `TSJ_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, r_ov && i_stall && !r_sv && w_fin_vld,
        r_sv, "finished request dropped at stalled output")
    `TSJ_ASSERT_IMPLIES(a_degen_zero, i_clk, i_rst_n, r_ov && r_od.degenerate,
        r_od.quality == '0, "degenerate response with nonzero quality")

endmodule
